// ===== design/smed_pkg.sv =====
// Shared constants and types for the sliding-window median filter.
package smed_pkg;

    localparam int WINDOW_MAX = 64;
    localparam int SAMPLE_W   = 32;
    localparam int SIZE_W     = 7;
    localparam int AGE_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W      = $clog2(WINDOW_MAX + 1);

    localparam logic [SIZE_W-1:0]   SIZE_RESET = SIZE_W'(3);
    localparam logic [SAMPLE_W-1:0] SIGN_FLIP  = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef logic [SAMPLE_W-1:0] t_key;
    typedef logic [AGE_W-1:0]    t_age;
    typedef logic [CNT_W-1:0]    t_cnt;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic en;
        logic full;
        t_age nm1;
        t_key key;
        t_key old_key;
    } t_ctrl;

    // What a cell shows its neighbors.
    typedef struct packed {
        t_key value;
        t_age age;
        logic gt_key;
        logic above;
    } t_link;

    localparam t_link LINK_LOW  = '{value: '0, age: '0, gt_key: 1'b0, above: 1'b0};
    localparam t_link LINK_HIGH = '{value: '0, age: '0, gt_key: 1'b1, above: 1'b1};

endpackage

// ===== design/smed_if.sv =====
// Handshake channels for samples, medians and the window size register.
interface smed_sample_if import smed_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface smed_median_if import smed_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] median;
    modport source (output valid, output median, input ready);
    modport sink   (input valid, input median, output ready);
endinterface

interface smed_cfg_if import smed_pkg::*;;
    logic              valid;
    logic              ready;
    logic [SIZE_W-1:0] window_size;
    modport source (output valid, output window_size, input ready);
    modport sink   (input valid, input window_size, output ready);
endinterface

// ===== design/smed_cell.sv =====
// One sorted-window cell: holds a value and its age, shifts with its neighbors.
module smed_cell import smed_pkg::*; (
    input  logic  i_clk,
    input  t_ctrl i_ctrl,
    input  logic  i_valid,
    input  t_link i_lo,
    input  t_link i_hi,
    output t_link o_link,
    output logic  o_old
);

    t_key r_value;
    t_age r_age;
    t_key n_value;
    t_age n_age;

    logic gt_key;
    logic old;
    logic above;
    t_key rem_value;
    t_age rem_age;
    logic rem_gt;
    t_key rem_lo_value;
    t_age rem_lo_age;
    logic rem_lo_gt;

    assign gt_key = !i_valid || (r_value > i_ctrl.key);
    assign old    = i_ctrl.full && i_valid && (r_age == i_ctrl.nm1);
    assign above  = i_ctrl.full && (!i_valid || (r_value > i_ctrl.old_key) ||
                                    ((r_value == i_ctrl.old_key) && !old));

    // Window after dropping the oldest entry, at this place and one below.
    assign rem_value    = i_hi.above ? i_hi.value  : r_value;
    assign rem_age      = i_hi.above ? i_hi.age    : r_age;
    assign rem_gt       = i_hi.above ? i_hi.gt_key : gt_key;
    assign rem_lo_value = above ? r_value : i_lo.value;
    assign rem_lo_age   = above ? r_age   : i_lo.age;
    assign rem_lo_gt    = above ? gt_key  : i_lo.gt_key;

    always_comb begin
        if (!rem_gt) begin
            n_value = rem_value;
            n_age   = rem_age + t_age'(1);
        end else if (rem_lo_gt) begin
            n_value = rem_lo_value;
            n_age   = rem_lo_age + t_age'(1);
        end else begin
            n_value = i_ctrl.key;
            n_age   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            r_value <= n_value;
            r_age   <= n_age;
        end
    end

    assign o_link = '{value: r_value, age: r_age, gt_key: gt_key, above: above};
    assign o_old  = old;

endmodule

// ===== design/sliding_window_median.sv =====
// Sliding-window median filter: sorted chain of cells and output control.
// Throughput: one sample per cycle unless a pending median is held at the output.
// Cells update in the transfer cycle; a median is pending once the window is full.
// The pending median moves from the chain into the output register when it is free.
// Reset: synchronous, active low; window size returns to 3 and the window is empty.
module sliding_window_median import smed_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    smed_sample_if.sink          i_sample,
    smed_median_if.source        o_median,
    smed_cfg_if.sink             i_cfg
);

    logic [SIZE_W-1:0] r_size;
    t_cnt              r_fill;
    logic              r_pend;
    logic              r_out_valid;
    t_key              r_median;

    t_cnt  win_n;
    t_age  nm1;
    t_age  mid;
    logic  full;
    logic  out_free;
    logic  in_xfer;
    logic  cfg_xfer;
    t_ctrl ctrl;
    t_key  old_key;
    t_key  mid_key;

    t_link                cell_link [WINDOW_MAX];
    logic [WINDOW_MAX-1:0] cell_old;
    logic [WINDOW_MAX-1:0] cell_valid;
    t_key                 old_term  [WINDOW_MAX];
    t_key                 mid_term  [WINDOW_MAX];

    always_comb begin
        if (r_size == '0) begin
            win_n = t_cnt'(1);
        end else if (32'(r_size) > 32'(WINDOW_MAX)) begin
            win_n = t_cnt'(WINDOW_MAX);
        end else begin
            win_n = t_cnt'(r_size);
        end
    end

    assign nm1      = t_age'(win_n - t_cnt'(1));
    assign mid      = nm1 >> 1;
    assign full     = (r_fill == win_n);
    assign out_free = !r_out_valid || o_median.ready;
    assign in_xfer  = i_sample.valid && i_sample.ready;
    assign cfg_xfer = i_cfg.valid && i_cfg.ready;

    assign i_sample.ready = !r_pend || out_free;
    assign i_cfg.ready    = 1'b1;

    assign ctrl = '{en: in_xfer, full: full, nm1: nm1,
                    key: t_key'(i_sample.sample) ^ SIGN_FLIP, old_key: old_key};

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_MAX; gi++) begin : g_cell
            t_link lo;
            t_link hi;
            if (gi == 0) begin : g_lo_edge
                assign lo = LINK_LOW;
            end else begin : g_lo
                assign lo = cell_link[gi-1];
            end
            if (gi == WINDOW_MAX - 1) begin : g_hi_edge
                assign hi = LINK_HIGH;
            end else begin : g_hi
                assign hi = cell_link[gi+1];
            end

            assign cell_valid[gi] = (t_cnt'(gi) < r_fill);
            assign old_term[gi]   = cell_old[gi] ? cell_link[gi].value : '0;
            assign mid_term[gi]   = (t_age'(gi) == mid) ? cell_link[gi].value : '0;

            smed_cell u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (ctrl),
                .i_valid (cell_valid[gi]),
                .i_lo    (lo),
                .i_hi    (hi),
                .o_link  (cell_link[gi]),
                .o_old   (cell_old[gi])
            );
        end
    endgenerate

    always_comb begin
        old_key = '0;
        mid_key = '0;
        for (int i = 0; i < WINDOW_MAX; i++) begin
            old_key = old_key | old_term[i];
            mid_key = mid_key | mid_term[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size      <= SIZE_RESET;
            r_fill      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_xfer) begin
                r_size <= i_cfg.window_size;
                r_fill <= '0;
            end else if (in_xfer && !full) begin
                r_fill <= r_fill + t_cnt'(1);
            end

            if (in_xfer) begin
                r_pend <= full || ((r_fill + t_cnt'(1)) == win_n);
            end else if (out_free) begin
                r_pend <= 1'b0;
            end

            if (r_pend && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_median.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend && out_free) begin
            r_median <= mid_key ^ SIGN_FLIP;
        end
    end

    assign o_median.valid  = r_out_valid;
    assign o_median.median = signed'(r_median);

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= win_n)
        else $error("fill count beyond window size");

    a_one_oldest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> $onehot(cell_old))
        else $error("full window without a single oldest cell");

    a_full_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && full) |=> r_pend)
        else $error("full window transfer without pending median");

    a_stall_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && r_out_valid && !o_median.ready) |-> !i_sample.ready)
        else $error("input taken while pending median is blocked");

endmodule

// ===== bench/tb_sliding_window_median.sv =====
// Self-checking testbench for the sliding-window median filter.
`timescale 1ns / 1ps

module tb_sliding_window_median import smed_pkg::*;;

    localparam int STALL_LIMIT = 2000;
    localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    smed_sample_if smp_if ();
    smed_median_if med_if ();
    smed_cfg_if    cfg_if ();

    sliding_window_median u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (smp_if),
        .o_median (med_if),
        .i_cfg    (cfg_if)
    );

    logic signed [SAMPLE_W-1:0] arrival_ring [WINDOW_MAX];
    logic signed [SAMPLE_W-1:0] ordered_win  [WINDOW_MAX];
    int unsigned                held_cnt;
    int unsigned                oldest_slot;
    logic [SIZE_W-1:0]          size_reg;

    logic signed [SAMPLE_W-1:0] pending_medians [$];

    int unsigned mismatches      = 0;
    int unsigned medians_checked = 0;
    int unsigned samples_sent    = 0;
    int unsigned size_writes     = 0;
    int unsigned random_sent     = 0;
    int unsigned idle_cycles     = 0;
    int unsigned hold_off_len    = 0;
    int unsigned longest_hold    = 0;
    bit          sample_gaps_on  = 1'b1;
    bit          median_stalls_on = 1'b1;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned eff_size(input logic [SIZE_W-1:0] sz);
        int unsigned n;
        n = sz;
        if (n == 0) n = 1;
        if (n > WINDOW_MAX) n = WINDOW_MAX;
        return n;
    endfunction

    task automatic insert_ordered(input int unsigned count, input logic signed [SAMPLE_W-1:0] key);
        int unsigned i;
        i = count;
        if (count >= WINDOW_MAX) return;
        while (i > 0 && ordered_win[i-1] > key) begin
            ordered_win[i] = ordered_win[i-1];
            i--;
        end
        ordered_win[i] = key;
    endtask

    task automatic advance_window(input logic signed [SAMPLE_W-1:0] s, output bit emits,
                                  output logic signed [SAMPLE_W-1:0] med);
        int unsigned n;
        int unsigned slot;
        int unsigned i;
        logic signed [SAMPLE_W-1:0] gone;
        n = eff_size(size_reg);
        emits = 1'b1;
        if (oldest_slot >= n) oldest_slot = 0;
        if (held_cnt < n) begin
            slot = (oldest_slot + held_cnt) % n;
            arrival_ring[slot] = s;
            insert_ordered(held_cnt, s);
            held_cnt++;
            if (held_cnt < n) emits = 1'b0;
        end else begin
            gone = arrival_ring[oldest_slot];
            i = 0;
            while (i < n && ordered_win[i] != gone) i++;
            while (i + 1 < n) begin
                ordered_win[i] = ordered_win[i+1];
                i++;
            end
            insert_ordered(n - 1, s);
            arrival_ring[oldest_slot] = s;
            oldest_slot = (oldest_slot + 1) % n;
        end
        med = ordered_win[(n-1)/2];
    endtask

    always @(posedge i_clk) begin
        logic signed [SAMPLE_W-1:0] expected_median;
        logic signed [SAMPLE_W-1:0] predicted;
        bit                         emits;
        if (!i_rst_n) begin
            held_cnt    = 0;
            oldest_slot = 0;
            size_reg    = SIZE_RESET;
        end else begin
            if (med_if.valid && med_if.ready) begin
                if (pending_medians.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected median %0d with none pending", med_if.median);
                end else begin
                    expected_median = pending_medians.pop_front();
                    medians_checked++;
                    if (med_if.median !== expected_median) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("median mismatch: expected %0d, got %0d",
                                     expected_median, med_if.median);
                    end
                end
            end
            if (cfg_if.valid && cfg_if.ready) begin
                size_reg    = cfg_if.window_size;
                held_cnt    = 0;
                oldest_slot = 0;
                size_writes++;
            end
            if (smp_if.valid && smp_if.ready) begin
                advance_window(smp_if.sample, emits, predicted);
                if (emits) pending_medians.push_back(predicted);
                samples_sent++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((smp_if.valid && smp_if.ready) || (med_if.valid && med_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", idle_cycles);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin : median_sink
        int unsigned stall;
        med_if.ready <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_off_len > 0) begin
                stall = hold_off_len;
                hold_off_len = 0;
                med_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
                if (stall > longest_hold) longest_hold = stall;
            end
            stall = median_stalls_on ? $urandom_range(0, 7) : 0;
            if (stall > 0) begin
                med_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            med_if.ready <= 1'b1;
            do @(posedge i_clk); while (!med_if.valid);
        end
    end

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
        int unsigned gap;
        gap = sample_gaps_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            smp_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        smp_if.valid  <= 1'b1;
        smp_if.sample <= s;
        do @(posedge i_clk); while (!smp_if.ready);
    endtask

    task automatic quiesce();
        smp_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_medians.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_window_size(input logic [SIZE_W-1:0] sz);
        quiesce();
        repeat (4) @(posedge i_clk);
        cfg_if.valid       <= 1'b1;
        cfg_if.window_size <= sz;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] draw_sample();
        int unsigned k;
        k = $urandom_range(0, 9);
        case (k)
            0: begin
                case ($urandom_range(0, 3))
                    0:       return S_MIN;
                    1:       return S_MAX;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            1:       return S_MIN + $urandom_range(0, 3);
            2:       return S_MAX - $urandom_range(0, 3);
            3, 4:    return $signed($urandom_range(0, 6)) - 3;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_default_window();
        send_sample(S_MIN);
        send_sample(S_MAX);
        send_sample('0);
        send_sample('1);
        send_sample(1);
        send_sample(S_MAX);
        send_sample(S_MAX);
        send_sample(S_MIN);
        send_sample(5);
        send_sample(5);
        send_sample(5);
    endtask

    task automatic test_pass_through();
        write_window_size(SIZE_W'(1));
        send_sample(S_MIN);
        send_sample(S_MAX);
        send_sample('1);
        write_window_size('0);
        send_sample('0);
        send_sample(S_MAX);
        send_sample(S_MIN);
    endtask

    task automatic test_even_window();
        write_window_size(SIZE_W'(2));
        send_sample(7);
        send_sample(7);
        send_sample(-3);
        send_sample(7);
        send_sample(S_MIN);
        send_sample(S_MAX);
    endtask

    task automatic test_random_windows();
        int unsigned phase;
        int unsigned pick;
        int unsigned items;
        phase = 0;
        while (random_sent < 1450) begin
            if (phase == 0)
                pick = 127;
            else if (phase == 1)
                pick = WINDOW_MAX;
            else begin
                case ($urandom_range(0, 19))
                    0:             pick = 0;
                    1:             pick = WINDOW_MAX;
                    2:             pick = $urandom_range(WINDOW_MAX + 1, 127);
                    3:             pick = 127;
                    4, 5, 6, 7, 8, 9:
                                   pick = $urandom_range(1, 4);
                    10, 11, 12, 13, 14, 15:
                                   pick = $urandom_range(5, 12);
                    default:       pick = $urandom_range(13, 40);
                endcase
            end
            write_window_size(pick[SIZE_W-1:0]);
            sample_gaps_on   = ($urandom_range(0, 3) != 0);
            median_stalls_on = ($urandom_range(0, 3) != 0);
            items = eff_size(pick[SIZE_W-1:0]) + $urandom_range(10, 60);
            repeat (items) begin
                send_sample(draw_sample());
                random_sent++;
            end
            phase++;
        end
        sample_gaps_on   = 1'b1;
        median_stalls_on = 1'b1;
    endtask

    task automatic test_input_backpressure();
        write_window_size(SIZE_W'(4));
        sample_gaps_on = 1'b0;
        hold_off_len   = 300;
        repeat (150) send_sample(draw_sample());
        sample_gaps_on = 1'b1;
    endtask

    initial begin
        smp_if.valid       <= 1'b0;
        smp_if.sample      <= '0;
        cfg_if.valid       <= 1'b0;
        cfg_if.window_size <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_window();
        test_pass_through();
        test_even_window();
        test_random_windows();
        test_input_backpressure();

        quiesce();
        repeat (8) @(posedge i_clk);

        $display("Ran %0d samples through %0d window size writes, %0d medians compared.",
                 samples_sent, size_writes, medians_checked);
        $display("Sizes spanned pass-through to saturated; output held off up to %0d cycles.",
                 longest_hold);
        if (mismatches == 0 && pending_medians.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches, %0d medians never arrived",
                     mismatches, pending_medians.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/smed_pkg.sv
design/smed_if.sv
design/smed_cell.sv
design/sliding_window_median.sv
bench/tb_sliding_window_median.sv
